[rtl/core/stereo_sine_tone_generator_assert.svh]
// Assertion macros used by the tone generator RTL.
`ifndef STEREO_SINE_TONE_GENERATOR_ASSERT_SVH
`define STEREO_SINE_TONE_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SSTG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sstg: assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SSTG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sstg: assertion failed");

`endif

[rtl/core/sstg_pkg.sv]
// Package with the shared types, constants and tables of the tone generator.
`default_nettype none

package sstg_pkg;

	localparam int unsigned ANGLE_BITS_DEFAULT = 16;
	localparam int unsigned PHASE_W = 18;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [PHASE_W-1:0] RATE_RESET = 18'd44100;
	localparam logic [PHASE_W-1:0] STEP_RESET = 18'd1000;

	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [30:0] Q30_ONE = 31'd1073741824;
	localparam logic [14:0] FULL_SCALE = 15'd32767;
	localparam logic [14:0] MAG_MAX = 15'd16383;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sd16383;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sd16383;

	localparam int unsigned NUM_TERMS = 6;
	localparam int unsigned TERM_W = 3;

	// Reciprocals ceil(2^(32+l)/d), rounded up, of the series divisors, 2^(l-1) < d <= 2^l.
	localparam logic [32:0] RECIP_T0 = 33'(((65'd1 << 40) + 65'd155) / 65'd156);
	localparam logic [32:0] RECIP_T1 = 33'(((65'd1 << 39) + 65'd109) / 65'd110);
	localparam logic [32:0] RECIP_T2 = 33'(((65'd1 << 39) + 65'd71) / 65'd72);
	localparam logic [32:0] RECIP_T3 = 33'(((65'd1 << 38) + 65'd41) / 65'd42);
	localparam logic [32:0] RECIP_T4 = 33'(((65'd1 << 37) + 65'd19) / 65'd20);
	localparam logic [32:0] RECIP_T5 = 33'(((65'd1 << 35) + 65'd5) / 65'd6);

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [PHASE_W-1:0] ph;
		logic               last;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic [32:0] term_recip(input logic [TERM_W-1:0] idx);
		logic [32:0] m;
		case (idx)
			3'd0: m = RECIP_T0;
			3'd1: m = RECIP_T1;
			3'd2: m = RECIP_T2;
			3'd3: m = RECIP_T3;
			3'd4: m = RECIP_T4;
			3'd5: m = RECIP_T5;
			default: m = RECIP_T0;
		endcase
		return m;
	endfunction

	function automatic logic [5:0] term_shift(input logic [TERM_W-1:0] idx);
		logic [5:0] s;
		case (idx)
			3'd0: s = 6'd40;
			3'd1: s = 6'd39;
			3'd2: s = 6'd39;
			3'd3: s = 6'd38;
			3'd4: s = 6'd37;
			3'd5: s = 6'd35;
			default: s = 6'd40;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

[rtl/core/stereo_sine_tone_generator.sv]
// Top level of the stereo sine tone generator: register port, front end, queue and sine engine.
//
// Each word accepted on the input channel (in_valid high, in_stall low at a rising edge)
// requests one stereo frame; last_of_block is carried through to block_end. Each request
// yields exactly one output word, in order, with the same sample on left_sample and
// right_sample. The output word is held in a register until out_stall is low.
// The front end updates the phase counter as the word is accepted and queues the phase in a
// two-entry queue, so up to two further requests are taken while the engine is busy or the
// receiver stalls; in_stall rises only when that queue is full.
// The engine works on one frame at a time: it loads the frame, runs the bit-serial divider
// that turns the phase into an angle, and then evaluates the sine series on the single
// shared multiplier; it waits in its last step while the output register is stalled.
// Reset clears the phase to zero, the rate register to 44100 and tone_step to 1000, and
// empties the queue and output register. Registers must be written by the user through the
// APB port only while no frame is in flight; the block does not enforce this. A rate of zero acts as one.
`default_nettype none

module stereo_sine_tone_generator #(
	parameter int unsigned ANGLE_BITS = sstg_pkg::ANGLE_BITS_DEFAULT
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [2:0]                           paddr,
	input  wire logic [sstg_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [sstg_pkg::CFG_DATA_W-1:0]           prdata,
	output logic                                      pready,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic                                 last_of_block,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [sstg_pkg::SAMPLE_W-1:0]      left_sample,
	output logic signed [sstg_pkg::SAMPLE_W-1:0]      right_sample,
	output logic                                      block_end
);
	import sstg_pkg::*;

	localparam logic REG_IDX_FRAME_RATE = 1'b0;
	localparam logic REG_IDX_TONE_STEP = 1'b1;

	logic [PHASE_W-1:0] frame_rate_q;
	logic [PHASE_W-1:0] tone_step_q;
	logic [PHASE_W-1:0] rate_eff;
	logic               cfg_write;

	queue_status_t      q_status;
	logic               q_push;
	entry_t             q_push_data;
	logic               q_pop;
	entry_t             q_pop_data;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign rate_eff = (frame_rate_q == '0) ? PHASE_W'(1) : frame_rate_q;

	always_comb begin
		unique case (paddr[2])
			REG_IDX_FRAME_RATE: prdata = CFG_DATA_W'(frame_rate_q);
			REG_IDX_TONE_STEP:  prdata = CFG_DATA_W'(tone_step_q);
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rate_q <= RATE_RESET;
			tone_step_q <= STEP_RESET;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_IDX_FRAME_RATE: frame_rate_q <= pwdata[PHASE_W-1:0];
				REG_IDX_TONE_STEP:  tone_step_q <= pwdata[PHASE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	sstg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.last_of_block(last_of_block),
		.rate_eff    (rate_eff),
		.tone_step   (tone_step_q),
		.q_status    (q_status),
		.q_push      (q_push),
		.q_push_data (q_push_data)
	);

	sstg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.status    (q_status)
	);

	sstg_back #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rate_eff     (rate_eff),
		.q_status     (q_status),
		.q_pop_data   (q_pop_data),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.block_end    (block_end)
	);

`include "stereo_sine_tone_generator_assert.svh"

	`SSTG_ASSERT_IMP(a_pop_not_empty, clk, arst_n, q_pop, !q_status.empty)
	`SSTG_ASSERT_NXT(a_push_fills, clk, arst_n, q_push && q_status.empty, !q_status.empty)
	`SSTG_ASSERT_IMP(a_channels_match, clk, arst_n, out_valid, left_sample == right_sample)
	`SSTG_ASSERT_IMP(a_sample_range, clk, arst_n, out_valid, (left_sample <= SAMPLE_MAX) && (left_sample >= SAMPLE_MIN))

endmodule

`default_nettype wire

[rtl/core/sstg_front.sv]
// Front end: takes frame requests, keeps the phase counter and queues each frame's phase.
`default_nettype none

module sstg_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        last_of_block,
	input  wire logic [sstg_pkg::PHASE_W-1:0] rate_eff,
	input  wire logic [sstg_pkg::PHASE_W-1:0] tone_step,
	input  wire sstg_pkg::queue_status_t     q_status,
	output logic                             q_push,
	output sstg_pkg::entry_t                 q_push_data
);
	import sstg_pkg::*;

	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] ph_eff;
	logic [PHASE_W-1:0] step_eff;
	logic [PHASE_W:0]   sum;
	logic [PHASE_W-1:0] phase_next;

	always_comb begin
		ph_eff = (phase_q >= rate_eff) ? '0 : phase_q;
		step_eff = (tone_step >= rate_eff) ? (rate_eff - PHASE_W'(1)) : tone_step;
		sum = {1'b0, ph_eff} + {1'b0, step_eff};
		if (sum >= {1'b0, rate_eff}) begin
			phase_next = PHASE_W'(sum - {1'b0, rate_eff});
		end else begin
			phase_next = sum[PHASE_W-1:0];
		end
	end

	assign in_stall = q_status.full;
	assign q_push = in_valid && !q_status.full;
	assign q_push_data = '{ph: ph_eff, last: last_of_block};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (q_push) begin
			phase_q <= phase_next;
		end
	end

endmodule

`default_nettype wire

[rtl/core/sstg_queue.sv]
// Short queue of frame words between the front end and the sine engine.
`default_nettype none

module sstg_queue (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  wire sstg_pkg::entry_t        push_data,
	input  wire logic                    pop,
	output sstg_pkg::entry_t             pop_data,
	output sstg_pkg::queue_status_t      status
);
	import sstg_pkg::*;

	entry_t                 slot_q [QUEUE_DEPTH];
	logic [QUEUE_IDX_W-1:0] wr_q;
	logic [QUEUE_IDX_W-1:0] rd_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	function automatic logic [QUEUE_IDX_W-1:0] next_idx(input logic [QUEUE_IDX_W-1:0] idx);
		return (idx == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : (idx + QUEUE_IDX_W'(1));
	endfunction

	assign pop_data = slot_q[rd_q];
	assign status.full = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= next_idx(wr_q);
			end
			if (pop) begin
				rd_q <= next_idx(rd_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

[rtl/core/sstg_back.sv]
// Sine engine: divides the phase into an angle and evaluates the sine on one shared multiplier.
`default_nettype none

module sstg_back #(
	parameter int unsigned ANGLE_BITS = sstg_pkg::ANGLE_BITS_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [sstg_pkg::PHASE_W-1:0]         rate_eff,
	input  wire sstg_pkg::queue_status_t             q_status,
	input  wire sstg_pkg::entry_t                    q_pop_data,
	output logic                                     q_pop,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [sstg_pkg::SAMPLE_W-1:0]     left_sample,
	output logic signed [sstg_pkg::SAMPLE_W-1:0]     right_sample,
	output logic                                     block_end
);
	import sstg_pkg::*;

	localparam int unsigned NUM_W = ANGLE_BITS + PHASE_W + 1;
	localparam int unsigned QUO_W = ANGLE_BITS + 1;
	localparam int unsigned U_W = ANGLE_BITS - 1;
	localparam int unsigned CNT_W = $clog2(ANGLE_BITS + 1);
	localparam int unsigned MUL_A_W = 32;
	localparam int unsigned MUL_B_W = 33;
	localparam int unsigned PROD_W = MUL_A_W + MUL_B_W;
	localparam logic [U_W-1:0] QUARTER = U_W'(1) << (ANGLE_BITS - 2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_THETA,
		ST_X2,
		ST_TERM_P,
		ST_TERM_Q,
		ST_FIN,
		ST_MAG
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [TERM_W-1:0]      term_q;
	logic [PHASE_W-1:0]     rem_q;
	logic [QUO_W-1:0]       quo_q;
	logic [1:0]             quad_q;
	logic [30:0]            theta_q;
	logic [31:0]            x2_q;
	logic [31:0]            y_q;
	logic [30:0]            t_q;
	logic [30:0]            s_q;
	logic                   last_q;
	logic                   out_valid_q;
	logic [SAMPLE_W-1:0]    sample_q;
	logic                   block_end_q;

	logic [NUM_W-1:0]       num;
	logic [PHASE_W:0]       trial;
	logic                   trial_ge;
	logic [ANGLE_BITS-1:0]  angle;
	logic [U_W-1:0]         u;
	logic [MUL_A_W-1:0]     mul_a;
	logic [MUL_B_W-1:0]     mul_b;
	logic [PROD_W-1:0]      prod;
	logic [PROD_W-1:0]      quot;
	logic [30:0]            t_next;
	logic [PROD_W-1:0]      mag_full;
	logic [14:0]            mag;
	logic [SAMPLE_W-1:0]    sample_val;
	logic                   out_free;

	always_comb begin
		num = (NUM_W'(q_pop_data.ph) << ANGLE_BITS) + NUM_W'(rate_eff >> 1);
		trial = {rem_q, quo_q[QUO_W-1]};
		trial_ge = (trial >= {1'b0, rate_eff});
		angle = quo_q[ANGLE_BITS-1:0];
		if (angle[ANGLE_BITS-2]) begin
			u = QUARTER - {1'b0, angle[ANGLE_BITS-3:0]};
		end else begin
			u = {1'b0, angle[ANGLE_BITS-3:0]};
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_THETA: begin
				mul_a = MUL_A_W'(u);
				mul_b = MUL_B_W'(HALF_PI_Q30);
			end
			ST_X2: begin
				mul_a = MUL_A_W'(theta_q);
				mul_b = MUL_B_W'(theta_q);
			end
			ST_TERM_P: begin
				mul_a = x2_q;
				mul_b = MUL_B_W'(t_q);
			end
			ST_TERM_Q: begin
				mul_a = y_q;
				mul_b = term_recip(term_q);
			end
			ST_FIN: begin
				mul_a = MUL_A_W'(theta_q);
				mul_b = MUL_B_W'(t_q);
			end
			ST_MAG: begin
				mul_a = MUL_A_W'(s_q);
				mul_b = MUL_B_W'(FULL_SCALE);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	always_comb begin
		quot = prod >> term_shift(term_q);
		t_next = (quot >= PROD_W'(Q30_ONE)) ? '0 : (Q30_ONE - quot[30:0]);
		mag_full = prod >> 31;
		mag = (mag_full > PROD_W'(MAG_MAX)) ? MAG_MAX : mag_full[14:0];
		sample_val = quad_q[1] ? (SAMPLE_W'(0) - SAMPLE_W'(mag)) : SAMPLE_W'(mag);
		out_free = !out_valid_q || !out_stall;
	end

	assign q_pop = (state_q == ST_IDLE) && !q_status.empty;
	assign out_valid = out_valid_q;
	assign left_sample = sample_q;
	assign right_sample = sample_q;
	assign block_end = block_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			term_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			quad_q <= '0;
			theta_q <= '0;
			x2_q <= '0;
			y_q <= '0;
			t_q <= '0;
			s_q <= '0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
			sample_q <= '0;
			block_end_q <= 1'b0;
		end else begin
			if ((state_q == ST_MAG) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_status.empty) begin
						rem_q <= num[NUM_W-1:QUO_W];
						quo_q <= num[QUO_W-1:0];
						last_q <= q_pop_data.last;
						cnt_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= trial_ge ? PHASE_W'(trial - {1'b0, rate_eff})
						: trial[PHASE_W-1:0];
					quo_q <= {quo_q[QUO_W-2:0], trial_ge};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(ANGLE_BITS)) begin
						state_q <= ST_THETA;
					end
				end
				ST_THETA: begin
					quad_q <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
					theta_q <= 31'(prod >> (ANGLE_BITS - 2));
					state_q <= ST_X2;
				end
				ST_X2: begin
					x2_q <= 32'(prod >> 30);
					t_q <= Q30_ONE;
					term_q <= '0;
					state_q <= ST_TERM_P;
				end
				ST_TERM_P: begin
					y_q <= 32'(prod >> 30);
					state_q <= ST_TERM_Q;
				end
				ST_TERM_Q: begin
					t_q <= t_next;
					if (term_q == TERM_W'(NUM_TERMS - 1)) begin
						state_q <= ST_FIN;
					end else begin
						term_q <= term_q + TERM_W'(1);
						state_q <= ST_TERM_P;
					end
				end
				ST_FIN: begin
					s_q <= 31'(prod >> 30);
					state_q <= ST_MAG;
				end
				ST_MAG: begin
					if (out_free) begin
						sample_q <= sample_val;
						block_end_q <= last_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[test/sstg_tb_pkg.sv]
// Register addresses shared by the tone generator testbench modules.
`timescale 1ns / 100ps

package sstg_tb_pkg;

	typedef enum logic [2:0] {
		REG_SAMPLE_RATE = 3'd0,
		REG_TONE_STEP   = 3'd4
	} reg_addr_e;

endpackage

[test/sstg_checker.sv]
// Checker that predicts each tone generator output word and compares it with the block.
`timescale 1ns / 100ps

module sstg_checker #(
	parameter int unsigned ANGLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic                                 pready,
	input  logic [2:0]                           paddr,
	input  logic [sstg_pkg::CFG_DATA_W-1:0]      pwdata,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic                                 last_of_block,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [sstg_pkg::SAMPLE_W-1:0] left_sample,
	input  logic signed [sstg_pkg::SAMPLE_W-1:0] right_sample,
	input  logic                                 block_end,
	output int                                   pending_frames,
	output int                                   mismatch_count
);
	import sstg_tb_pkg::*;

	localparam logic [63:0] Q30_UNIT = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] PEAK = 64'd32767;
	localparam logic [63:0] MAG_LIMIT = 64'd16383;
	localparam logic [63:0] QUARTER = 64'd1 << (ANGLE_BITS - 2);

	typedef struct packed {
		logic signed [sstg_pkg::SAMPLE_W-1:0] sample;
		logic                                 last;
	} frame_t;

	frame_t frames_q[$];
	logic [17:0] rate_reg;
	logic [17:0] step_reg;
	logic [17:0] phase_acc;
	int errors;

	// Sine of a phase given as a fraction of the rate, scaled to half of full scale.
	function automatic logic signed [sstg_pkg::SAMPLE_W-1:0] sine_of_phase(
		input logic [63:0] ph,
		input logic [63:0] rate
	);
		logic [63:0] angle;
		logic [63:0] r;
		logic [63:0] u;
		logic [63:0] theta;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] sub;
		logic [63:0] mag;
		logic [1:0] quad;
		int m;
		angle = ((ph << ANGLE_BITS) + (rate >> 1)) / rate;
		angle = angle & ((64'd1 << ANGLE_BITS) - 64'd1);
		quad = 2'(angle >> (ANGLE_BITS - 2));
		r = angle & (QUARTER - 64'd1);
		u = quad[0] ? (QUARTER - r) : r;
		theta = ((u << (32 - ANGLE_BITS)) * HALF_PI_Q30) >> 30;
		x2 = (theta * theta) >> 30;
		t = Q30_UNIT;
		// Horner form of the odd Taylor series, innermost term first.
		for (m = 6; m >= 1; m--) begin
			sub = ((x2 * t) >> 30) / 64'(2 * m * (2 * m + 1));
			t = (sub >= Q30_UNIT) ? 64'd0 : (Q30_UNIT - sub);
		end
		mag = (((theta * t) >> 30) * PEAK) >> 31;
		if (mag > MAG_LIMIT)
			mag = MAG_LIMIT;
		return quad[1] ? (16'd0 - mag[15:0]) : mag[15:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		logic [63:0] rate_e;
		logic [63:0] step_e;
		logic [63:0] ph;
		frame_t want;
		frame_t next_frame;
		if (!arst_n) begin
			rate_reg = sstg_pkg::RATE_RESET;
			step_reg = sstg_pkg::STEP_RESET;
			phase_acc = '0;
			frames_q.delete();
			errors = 0;
			pending_frames <= 0;
			mismatch_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == REG_SAMPLE_RATE)
					rate_reg = pwdata[17:0];
				else if (paddr == REG_TONE_STEP)
					step_reg = pwdata[17:0];
			end
			if (in_valid && !in_stall) begin
				rate_e = (rate_reg == '0) ? 64'd1 : 64'(rate_reg);
				step_e = (64'(step_reg) >= rate_e) ? rate_e - 64'd1 : 64'(step_reg);
				ph = (64'(phase_acc) >= rate_e) ? 64'd0 : 64'(phase_acc);
				next_frame.sample = sine_of_phase(ph, rate_e);
				next_frame.last = last_of_block;
				frames_q.push_back(next_frame);
				ph = ph + step_e;
				if (ph >= rate_e)
					ph = ph - rate_e;
				phase_acc = ph[17:0];
			end
			if (out_valid && !out_stall) begin
				if (frames_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("Unexpected word: left %0d right %0d end %0b.",
							left_sample, right_sample, block_end);
				end else begin
					want = frames_q.pop_front();
					if (left_sample !== want.sample || right_sample !== want.sample ||
						block_end !== want.last) begin
						errors++;
						if (errors <= 10)
							$display("Mismatch: expected left %0d right %0d end %0b, got left %0d right %0d end %0b.",
								want.sample, want.sample, want.last,
								left_sample, right_sample, block_end);
					end
				end
			end
			pending_frames <= frames_q.size();
			mismatch_count <= errors;
		end
	end

endmodule

[test/tb_top.sv]
// Testbench top for the stereo sine tone generator: stimulus, register writes and verdict.
`timescale 1ns / 100ps

module tb_top;
	import sstg_tb_pkg::*;

	localparam int unsigned ANGLE_BITS = sstg_pkg::ANGLE_BITS_DEFAULT;
	localparam int RANDOM_WORDS = 900;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [sstg_pkg::CFG_DATA_W-1:0] pwdata = '0;
	logic [sstg_pkg::CFG_DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic last_of_block = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [sstg_pkg::SAMPLE_W-1:0] left_sample;
	logic signed [sstg_pkg::SAMPLE_W-1:0] right_sample;
	logic block_end;
	int pending_frames;
	int mismatch_count;
	int idle_pct = 0;
	int stall_pct = 0;

	stereo_sine_tone_generator #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.last_of_block(last_of_block),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_sample(left_sample),
		.right_sample(right_sample),
		.block_end(block_end)
	);

	sstg_checker #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.last_of_block(last_of_block),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_sample(left_sample),
		.right_sample(right_sample),
		.block_end(block_end),
		.pending_frames(pending_frames),
		.mismatch_count(mismatch_count)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	task automatic send_word(input logic last);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		last_of_block <= last;
		do @(posedge clk); while (in_stall);
	endtask

	// The count from the checker is registered, so look only after a further edge.
	task automatic wait_idle;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_frames != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input reg_addr_e addr, input logic [17:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {(($urandom_range(0, 1) == 1) ? 14'($urandom()) : 14'd0), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic retune(input logic [17:0] rate, input logic [17:0] step);
		wait_idle();
		write_reg(REG_SAMPLE_RATE, rate);
		write_reg(REG_TONE_STEP, step);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_directed(input int count);
		int k;
		for (k = 0; k < count; k++)
			send_word(k[0]);
	endtask

	task automatic retune_random;
		logic [17:0] rate;
		logic [17:0] rate_e;
		logic [17:0] step;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			rate = 18'($urandom_range(8000, 192000));
		else if (pick < 8)
			rate = 18'($urandom_range(1, 16));
		else if (pick == 8)
			rate = 18'($urandom());
		else
			rate = '0;
		rate_e = (rate == '0) ? 18'd1 : rate;
		pick = $urandom_range(0, 9);
		if (pick < 8)
			step = 18'($urandom_range(0, rate_e - 1));
		else
			step = 18'($urandom_range(rate_e, 18'h3FFFF));
		retune(rate, step);
	endtask

	initial begin
		int sent;
		int chunk;
		int n;
		int k;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings first, then quadrant walk, zero rate, wide rates and a rate drop.
		send_directed(3);
		retune(18'd4, 18'd1);
		send_directed(5);
		retune(18'd0, 18'd5);
		send_directed(2);
		retune(18'h3FFFF, 18'h3FFFF);
		send_directed(3);
		retune(18'd7, 18'd3);
		send_directed(2);
		retune(18'd1, 18'd0);
		send_directed(2);
		retune(18'd192000, 18'd191999);
		send_directed(3);

		sent = 0;
		chunk = 0;
		while (sent < RANDOM_WORDS) begin
			retune_random();
			case (chunk % 4)
				0: begin
					idle_pct <= 0;
					stall_pct <= 0;
				end
				1: begin
					idle_pct <= 74;
					stall_pct <= 0;
				end
				2: begin
					idle_pct <= 0;
					stall_pct <= 74;
				end
				default: begin
					idle_pct <= 32;
					stall_pct <= 32;
				end
			endcase
			n = $urandom_range(10, 40);
			for (k = 0; k < n; k++)
				send_word($urandom_range(0, 7) == 0);
			sent += n;
			chunk++;
		end

		wait_idle();
		repeat (ANGLE_BITS + 26) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS stereo_sine_tone_generator");
		else
			$display("FAIL stereo_sine_tone_generator");
		$finish;
	end

	initial begin
		#(10_000_000);
		$display("FAIL stereo_sine_tone_generator");
		$finish;
	end

endmodule
